/* design/gdd_pkg.sv */
`default_nettype none

package gdd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DNUM_W  = 23;
  localparam int unsigned COUNT_W = 23;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 43699
  localparam int unsigned  PROD_W      = 28;
  localparam logic [12:0]  RECIP_100   = 13'd5243;
  localparam int unsigned  RECIP_SHIFT = 19;

  localparam logic [DNUM_W-1:0]  DAYS_PER_YEAR = DNUM_W'(365);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 23'h3F_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_BEFORE  = '1;
  localparam logic [MONTH_W-1:0] MONTH_MAR     = 4'd3;

  typedef logic [DNUM_W-1:0]  dnum_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // Days in the year before the first of the month; month zero acts as
  // January and months past December act as December.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
    logic [8:0] days;
    case (month)
      4'd0, 4'd1: days = 9'd0;
      4'd2:       days = 9'd31;
      4'd3:       days = 9'd59;
      4'd4:       days = 9'd90;
      4'd5:       days = 9'd120;
      4'd6:       days = 9'd151;
      4'd7:       days = 9'd181;
      4'd8:       days = 9'd212;
      4'd9:       days = 9'd243;
      4'd10:      days = 9'd273;
      4'd11:      days = 9'd304;
      default:    days = 9'd334;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

/* design/gdd_day_number.sv */
`default_nettype none

module gdd_day_number
  import gdd_pkg::*;
(
  input  date_t date,
  output dnum_t dnum
);

  logic [YEAR_W:0]   y_p3;
  logic [YEAR_W:0]   y_p99;
  logic [YEAR_W:0]   y_p399;
  logic [PROD_W-1:0] p99;
  logic [PROD_W-1:0] p399;
  logic [PROD_W-1:0] py;
  logic [12:0]       leaps4;
  logic [7:0]        q100;
  logic [5:0]        q400;
  logic [7:0]        qy;
  logic [YEAR_W-1:0] hund;
  logic [12:0]       leaps;
  logic              leap;
  logic [DNUM_W-1:0] y365;

  // Leap years before this one: ceil(y/4) - ceil(y/100) + ceil(y/400)
  assign y_p3   = {1'b0, date.year} + (YEAR_W+1)'(3);
  assign y_p99  = {1'b0, date.year} + (YEAR_W+1)'(99);
  assign y_p399 = {1'b0, date.year} + (YEAR_W+1)'(399);

  assign p99  = PROD_W'(y_p99) * PROD_W'(RECIP_100);
  assign p399 = PROD_W'(y_p399) * PROD_W'(RECIP_100);
  assign py   = PROD_W'(date.year) * PROD_W'(RECIP_100);

  assign leaps4 = y_p3[YEAR_W:2];
  assign q100   = p99[RECIP_SHIFT+7:RECIP_SHIFT];
  assign q400   = p399[RECIP_SHIFT+7:RECIP_SHIFT+2];
  assign leaps  = leaps4 - 13'(q100) + 13'(q400);

  // Leap test: divisible by 4, and not a century unless the century count is a multiple of 4
  assign qy   = py[RECIP_SHIFT+7:RECIP_SHIFT];
  assign hund = YEAR_W'({qy, 6'b0}) + YEAR_W'({qy, 5'b0}) + YEAR_W'({qy, 2'b0});
  assign leap = (date.year[1:0] == 2'b00) && ((date.year != hund) || (qy[1:0] == 2'b00));

  assign y365 = DNUM_W'(date.year) * DAYS_PER_YEAR;

  assign dnum = y365 + DNUM_W'(leaps) + DNUM_W'(days_before_month(date.month))
              + DNUM_W'(date.day) + DNUM_W'(leap && (date.month >= MONTH_MAR));

endmodule

`default_nettype wire

/* design/gdd_diff.sv */
`default_nettype none

module gdd_diff
  import gdd_pkg::*;
(
  input  date_t  start_date,
  input  date_t  end_date,
  input  dnum_t  start_num,
  input  dnum_t  end_num,
  output count_t count
);

  logic          end_first;
  logic [DNUM_W:0] diff;

  assign end_first = (end_date.year < start_date.year)
               || ((end_date.year == start_date.year)
                   && ((end_date.month < start_date.month)
                       || ((end_date.month == start_date.month)
                           && (end_date.day < start_date.day))));

  assign diff = {1'b0, end_num} - {1'b0, start_num};

  // -1 if end is first; clamp big spans; negatives from odd day numbers pass as is
  always_comb begin
    if (end_first) begin
      count = COUNT_BEFORE;
    end else if (!diff[DNUM_W] && diff[DNUM_W-1]) begin
      count = COUNT_MAX;
    end else begin
      count = diff[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* design/gregorian_day_difference.sv */
`default_nettype none

// Gregorian day difference.
//
// Input channel: one word carries a start date and an end date, each as
// year, month and day. A word is taken on a rising edge of clk with
// in_valid high and in_stall low.
// Result channel: one word per input word, out_day_count, the signed number
// of days from start to end, -1 when the end date comes before the start
// date, clamped to 4194303 for spans beyond the field.
// out_valid rises as the word moves from the input to the result stage.
// Throughput: one word per cycle while the result side drains; the two
// registered stages (input and result) each hold one word.
// Reset (rst_n low at a clock edge) empties both stages; no result is shown
// afterwards until a new word arrives.
// When the receiver holds out_stall, the result word stays put, the input
// stage still fills once, and in_stall rises only when both stages are full.

module gregorian_day_difference
  import gdd_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst_n,

  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  [YEAR_W-1:0]         in_start_year,
  input  wire  [MONTH_W-1:0]        in_start_month,
  input  wire  [DAY_W-1:0]          in_start_day,
  input  wire  [YEAR_W-1:0]         in_end_year,
  input  wire  [MONTH_W-1:0]        in_end_month,
  input  wire  [DAY_W-1:0]          in_end_day,

  output logic                      out_valid,
  input  wire                       out_stall,
  output logic signed [COUNT_W-1:0] out_day_count
);

  logic   in_valid_r;
  date_t  start_r;
  date_t  end_r;
  logic   out_valid_r;
  count_t count_r;
  count_t count_nxt;
  dnum_t  start_num;
  dnum_t  end_num;
  logic   out_adv;
  logic   in_adv;

  // Advance each stage when it is empty or the stage after it moves on
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_adv   = !in_valid_r || out_adv;
  assign in_stall = !in_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_adv) begin
      in_valid_r <= in_valid;
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      start_r <= '{year: in_start_year, month: in_start_month, day: in_start_day};
      end_r   <= '{year: in_end_year, month: in_end_month, day: in_end_day};
    end
  end

  gdd_day_number u_start_num (
    .date (start_r),
    .dnum (start_num)
  );

  gdd_day_number u_end_num (
    .date (end_r),
    .dnum (end_num)
  );

  gdd_diff u_diff (
    .start_date (start_r),
    .end_date   (end_r),
    .start_num  (start_num),
    .end_num    (end_num),
    .count      (count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  // Hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (out_adv && in_valid_r) begin
      count_r <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_day_count = $signed(count_r);

endmodule

`default_nettype wire

/* design/gdd_checker.sv */
`default_nettype none

module gdd_checker
  import gdd_pkg::*;
(
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input wire [YEAR_W-1:0]   in_start_year,
  input wire [MONTH_W-1:0]  in_start_month,
  input wire [DAY_W-1:0]    in_start_day,
  input wire [YEAR_W-1:0]   in_end_year,
  input wire [MONTH_W-1:0]  in_end_month,
  input wire [DAY_W-1:0]    in_end_day,
  input wire                out_valid,
  input wire                out_stall,
  input wire [COUNT_W-1:0]  out_day_count
);

  logic same_dates;

  assign same_dates = (in_start_year == in_end_year) && (in_start_month == in_end_month)
                   && (in_start_day == in_end_day);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side free");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_same_date_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && same_dates) ##1 !out_stall
      |=> (out_valid && (out_day_count == '0)))
    else $error("equal dates did not give zero after two cycles");

endmodule

bind gregorian_day_difference gdd_checker u_gdd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_start_year  (in_start_year),
  .in_start_month (in_start_month),
  .in_start_day   (in_start_day),
  .in_end_year    (in_end_year),
  .in_end_month   (in_end_month),
  .in_end_day     (in_end_day),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_day_count  (out_day_count)
);

`default_nettype wire

/* tb/testbench.sv */
module testbench;
  import gdd_pkg::*;

  // Cycle limit for the watchdog, well above what a correct run needs even
  // with both sides idling hard, so this leaves a wide margin.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int WORDS_PER_RUN = 175;  // random words in each idling stretch
  localparam int PRINT_CAP     = 40;   // stop printing mismatches after this many

  // One directed word: the two dates and, where it is obvious, the count
  // typed in by hand.
  typedef struct packed {
    date_t  start_date;
    date_t  end_date;
    logic   typed;
    count_t want;
  } row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [YEAR_W-1:0]    in_start_year  = '0;
  logic [MONTH_W-1:0]   in_start_month = '0;
  logic [DAY_W-1:0]     in_start_day   = '0;
  logic [YEAR_W-1:0]    in_end_year    = '0;
  logic [MONTH_W-1:0]   in_end_month   = '0;
  logic [DAY_W-1:0]     in_end_day     = '0;

  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic signed [COUNT_W-1:0] out_day_count;

  // Day counts still owed by the block, oldest first.
  count_t expected_counts[$];
  row_t   directed_rows[$];

  int mismatches  = 0;
  int cycle_count = 0;

  // Idling odds in percent, changed per stretch by the stimulus process.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Days in the year ahead of the first of each month. Month zero acts as
  // January; thirteen to fifteen act as December.
  int unsigned days_ahead [16] = '{0, 0, 31, 59, 90, 120, 151, 181,
                                   212, 243, 273, 304, 334, 334, 334, 334};

  gregorian_day_difference u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_year  (in_start_year),
    .in_start_month (in_start_month),
    .in_start_day   (in_start_day),
    .in_end_year    (in_end_year),
    .in_end_month   (in_end_month),
    .in_end_day     (in_end_day),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_day_count  (out_day_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_leap(input longint unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4 == 0);
  endfunction

  // Absolute day number: every year before y in full, then the days of y up
  // to and including the given day. Day and month are taken as given, with
  // no check, so impossible dates still map to some number.
  function automatic longint unsigned day_index(input logic [YEAR_W-1:0]  y,
                                                input logic [MONTH_W-1:0] m,
                                                input logic [DAY_W-1:0]   d);
    longint unsigned yy;
    longint unsigned n;
    yy = y;
    n  = yy * 365 + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
    n  = n + days_ahead[m] + d;
    if (m >= MONTH_MAR && is_leap(yy)) n = n + 1;
    return n;
  endfunction

  // Order by year, then month, then day.
  function automatic bit earlier(input date_t a, input date_t b);
    if (a.year != b.year)   return a.year < b.year;
    if (a.month != b.month) return a.month < b.month;
    return a.day < b.day;
  endfunction

  // Days from start to end: the all-ones code when the end comes first,
  // clamped at the top of the field, otherwise wrapped to the field width
  // (bad day numbers can make a forward pair come out negative).
  function automatic count_t span_days(input date_t s, input date_t e);
    longint diff;
    if (earlier(e, s)) return COUNT_BEFORE;
    diff = longint'(day_index(e.year, e.month, e.day))
         - longint'(day_index(s.year, s.month, s.day));
    if (diff > longint'(COUNT_MAX)) diff = longint'(COUNT_MAX);
    return count_t'(diff);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int month_len(input logic [YEAR_W-1:0] y,
                                   input logic [MONTH_W-1:0] m);
    case (m)
      4'd2:                   return is_leap(y) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default:                return 31;
    endcase
  endfunction

  function automatic date_t valid_date(input logic [YEAR_W-1:0] y);
    date_t d;
    d.year  = y;
    d.month = MONTH_W'($urandom_range(12, 1));
    d.day   = DAY_W'($urandom_range(month_len(y, d.month), 1));
    return d;
  endfunction

  // Mostly real calendar pairs in forward order, some turned round, and the
  // rest raw field noise that reaches every bit pattern the ports allow.
  task automatic pick_pair(output date_t s, output date_t e);
    int    kind;
    date_t t;
    kind = $urandom_range(99);
    if (kind < 82) begin
      s = valid_date(YEAR_W'($urandom_range(9999)));
      case ($urandom_range(3))
        0:       e = s;
        1:       e = valid_date(s.year);
        2:       e = valid_date((s.year > 9996) ? s.year
                                : YEAR_W'(s.year + $urandom_range(3)));
        default: e = valid_date(YEAR_W'($urandom_range(9999)));
      endcase
      // swap so that forward pairs run forwards and the others backwards
      if (earlier(e, s) == (kind < 70)) begin
        t = s;
        s = e;
        e = t;
      end
    end else begin
      s.year  = YEAR_W'($urandom_range(16383));
      s.month = MONTH_W'($urandom_range(15));
      s.day   = DAY_W'($urandom_range(31));
      e.year  = YEAR_W'($urandom_range(16383));
      e.month = MONTH_W'($urandom_range(15));
      e.day   = DAY_W'($urandom_range(31));
      // share the year or the month often, so the finer comparisons matter
      if ($urandom_range(1) == 0) e.year = s.year;
      if ($urandom_range(3) == 0) e.month = s.month;
    end
  endtask

  task automatic add_row(input int sy, input int sm, input int sd,
                         input int ey, input int em, input int ed,
                         input bit typed, input count_t want);
    row_t r;
    r.start_date = '{year: YEAR_W'(sy), month: MONTH_W'(sm), day: DAY_W'(sd)};
    r.end_date   = '{year: YEAR_W'(ey), month: MONTH_W'(em), day: DAY_W'(ed)};
    r.typed      = typed;
    r.want       = want;
    directed_rows.push_back(r);
  endtask

  // Send one word. Entered and left at a falling edge. Idle gaps come first,
  // then the word is held until the block takes it, and the count it owes
  // is queued at that same edge.
  task automatic drive_word(input date_t s, input date_t e,
                            input bit typed, input count_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_start_year  <= s.year;
    in_start_month <= s.month;
    in_start_day   <= s.day;
    in_end_year    <= e.year;
    in_end_month   <= e.month;
    in_end_day     <= e.day;
    do @(posedge clk); while (in_stall);
    expected_counts.push_back(typed ? want : span_days(s, e));
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("testbench: mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall at random, check every word taken
  // ---------------------------------------------------------------------------

  // Change the stall at the falling edge only, so it is settled well before
  // the block samples it.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // A word leaves the block on a rising edge with out_valid high and
  // out_stall low; compare it with the oldest count still owed.
  always @(posedge clk) begin : check_results
    count_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("result word %0d with nothing owed",
                                  out_day_count));
      end else begin
        want = expected_counts.pop_front();
        if (out_day_count !== want)
          report_mismatch($sformatf("day_count %0d (0x%06h), expected %0d (0x%06h)",
                                    out_day_count, out_day_count,
                                    $signed(want), want));
      end
    end
  end

  // Watchdog: give up on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    date_t s;
    date_t e;
    row_t  r;

    // Directed words. Columns: start y/m/d, end y/m/d, typed, count.
    // Rows without a typed count are checked against the predictor.
    add_row(2000,  1,  1,  2000,  1,  1,  1, count_t'(0));   // same date
    add_row(2000,  1,  2,  2000,  1,  1,  1, COUNT_BEFORE);  // end a day early
    add_row(2001,  3,  2,  2001,  3,  1,  1, COUNT_BEFORE);  // back by day
    add_row(2001,  5,  1,  2001,  4, 30,  1, COUNT_BEFORE);  // back by month
    add_row(2002,  1,  1,  2001, 12, 31,  1, COUNT_BEFORE);  // back by year
    add_row(   0,  1,  1,  9999, 12, 31,  1, count_t'(3652424)); // full range
    add_row(   0,  0,  0, 16383, 15, 31,  1, COUNT_MAX);     // clamp at the top
    add_row(   0,  1,  1, 11484,  1,  1,  0, '0);            // just over the clamp
    add_row(16383, 15, 31, 16383, 15, 31, 1, count_t'(0));   // all ones, equal
    add_row(2000, 12, 31,  2001,  1,  1,  1, count_t'(1));   // year roll-over
    add_row(2000,  2, 28,  2000,  3,  1,  1, count_t'(2));   // leap by 400
    add_row(1900,  2, 28,  1900,  3,  1,  1, count_t'(1));   // century, no leap
    add_row(2004,  2, 28,  2004,  3,  1,  1, count_t'(2));   // leap by 4
    add_row(   0,  2, 28,     0,  3,  1,  1, count_t'(2));   // year zero leaps
    add_row(1999,  1,  1,  2001,  1,  1,  0, '0);            // across a leap
    add_row(2001,  0,  5,  2001,  1,  5,  1, count_t'(0));   // month zero
    add_row(2001,  1,  5,  2001,  0,  5,  1, COUNT_BEFORE);  // month zero ranks low
    add_row(2000, 13,  1,  2000, 15,  1,  1, count_t'(0));   // past December
    add_row(2001, 12, 31,  2001, 13,  1,  0, '0);            // negative wrap
    add_row(2001,  2, 31,  2001,  3,  1,  1, 23'h7F_FFFE);   // Feb 31 to Mar 1
    add_row(2001,  3,  0,  2001,  3,  1,  1, count_t'(1));   // day zero
    add_row(2001,  3, 31,  2001,  4, 31,  0, '0);            // day past month end
    add_row(9999, 12, 31,  9999, 12, 31,  1, count_t'(0));
    add_row(8191,  7, 16,  8192,  8, 15,  0, '0);            // year bit pattern

    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with no idling on either side.
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      drive_word(r.start_date, r.end_date, r.typed, r.want);
    end

    // Random part: two passes through the four idling stretches.
    for (int pass = 0; pass < 2; pass++) begin
      for (int stretch = 0; stretch < 4; stretch++) begin
        case (stretch)
          0:       begin send_idle_pct = 0;  stall_pct = 0;  end
          1:       begin send_idle_pct = 71; stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  stall_pct = 71; end
          default: begin send_idle_pct = 37; stall_pct = 37; end
        endcase
        for (int n = 0; n < WORDS_PER_RUN; n++) begin
          pick_pair(s, e);
          drive_word(s, e, 1'b0, '0);
        end
      end
    end

    // Drop valid, drain what is owed, then allow the pipeline to settle
    // so that any stray word shows up before the verdict.
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
design/gdd_pkg.sv
design/gdd_day_number.sv
design/gdd_diff.sv
design/gregorian_day_difference.sv
design/gdd_checker.sv
tb/testbench.sv
